// ----- design/sha_pkg.sv -----
// SHA-256 package: round constants, initial hash values, a rotate function and the core control struct.
// Used by the compression core and the top level; no dependencies.
package sha_pkg;
	localparam int DigestWords = 8;
	localparam int BlockWords = 16;
	localparam int Rounds = 64;
	localparam logic [5:0] LengthSlot = 6'd56;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t initial_hash(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} core_ctl_t;
endpackage

// ----- design/sha_core.sv -----
// SHA-256 compression core: one round per cycle, schedule in a 16-word window.
// Depends on sha_pkg.
module sha_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sha_pkg::word_t block [sha_pkg::BlockWords],
	input  logic init_chain,
	output sha_pkg::word_t chain [sha_pkg::DigestWords],
	output sha_pkg::core_ctl_t ctl
);
	sha_pkg::word_t w_q [sha_pkg::BlockWords];
	sha_pkg::word_t v_q [sha_pkg::DigestWords];
	sha_pkg::word_t h_q [sha_pkg::DigestWords];
	logic [5:0] round_q;
	logic busy_q, done_q;
	sha_pkg::word_t s0, s1, w_new, big0, big1, ch, maj, t1, t2;

	always_comb begin
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		big1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
		big0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + big1 + ch + sha_pkg::round_k(round_q) + w_q[0];
		t2 = big0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < sha_pkg::DigestWords; i++) h_q[i] <= sha_pkg::initial_hash(3'(i));
		end else begin
			done_q <= 1'b0;
			if (init_chain) begin
				for (int i = 0; i < sha_pkg::DigestWords; i++)
					h_q[i] <= sha_pkg::initial_hash(3'(i));
			end else if (start && !busy_q) begin
				busy_q <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'(sha_pkg::Rounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					h_q[0] <= h_q[0] + t1 + t2;
					h_q[1] <= h_q[1] + v_q[0];
					h_q[2] <= h_q[2] + v_q[1];
					h_q[3] <= h_q[3] + v_q[2];
					h_q[4] <= h_q[4] + v_q[3] + t1;
					h_q[5] <= h_q[5] + v_q[4];
					h_q[6] <= h_q[6] + v_q[5];
					h_q[7] <= h_q[7] + v_q[6];
				end
			end
		end
	end

	// Working variables and the schedule window carry no reset.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			for (int i = 0; i < sha_pkg::BlockWords; i++) w_q[i] <= block[i];
			for (int i = 0; i < sha_pkg::DigestWords; i++) v_q[i] <= h_q[i];
		end else if (busy_q) begin
			for (int i = 0; i < sha_pkg::BlockWords - 1; i++) w_q[i] <= w_q[i+1];
			w_q[sha_pkg::BlockWords-1] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign chain = h_q;
	assign ctl = '{start: start, busy: busy_q, done: done_q};

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && round_q == 6'd63 |=> done_q && !busy_q) else $error("done missing");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
	a_round_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> round_q == 6'd0) else $error("round not cleared");
endmodule

// ----- design/sha256_message_hasher.sv -----
// SHA-256 message hasher top level: byte packer, padding sequencer, digest output.
// Depends on sha_pkg and sha_core.
//
// Usage: bytes enter on s_axis (tdata = data_byte, tuser = {end_of_message,has_byte}).
// Each byte is packed big-endian into a 64-byte block. A full block runs through
// the shared round unit, one round per cycle, through a load state and a wait for
// the result, during which s_axis_tready is low. An ordinary byte that does not
// fill the block leaves s_axis_tready high for the next byte.
// On end_of_message the sequencer inserts 0x80, zero fill and the 64-bit bit
// length one byte per cycle, compressing one or two blocks, then presents the
// eight digest words on m_axis, tdata = {last_word, word_index, digest_word}.
// When the receiver stalls, the current digest word holds on m_axis and input
// stays blocked until the eighth word is taken; the chain then returns to the
// initial hash. Reset clears the length, position and control state, loads the
// initial hash and leaves the block buffer undefined until written.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,  // [0] has_byte, [1] end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [31:0] digest_word, [34:32] word_index, [35] last_word
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COMP = 5'b00010,
		ST_PAD  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	sha_pkg::word_t block_q [sha_pkg::BlockWords];
	sha_pkg::word_t chain [sha_pkg::DigestWords];
	sha_pkg::core_ctl_t ctl;
	logic [63:0] len_q, pad_len_q;
	logic [5:0] pos_q;
	logic closing_q, pad_mark_q;
	logic done_len_q, tail_q;
	logic [2:0] out_idx_q;
	logic start, init_chain, put, accept;
	logic [7:0] put_byte;
	logic [3:0] len_idx;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign len_idx = 4'(pos_q) - 4'd8; // length byte index 0..7 at slots 56..63

	always_comb begin
		put = 1'b0;
		put_byte = 8'h00;
		if (state_q == ST_IDLE && accept && s_axis_tuser[0]) begin
			put = 1'b1;
			put_byte = s_axis_tdata;
		end else if (state_q == ST_PAD) begin
			put = 1'b1;
			if (pad_mark_q) put_byte = 8'h80;
			else if (pos_q >= sha_pkg::LengthSlot && !tail_q)
				put_byte = 8'(pad_len_q >> (6'd8 * (6'd7 - 6'(len_idx[2:0]))));
		end
	end

	assign start = (state_q == ST_COMP);
	assign init_chain = (state_q == ST_OUT) && m_axis_tready && (out_idx_q == 3'd7);

	// Block buffer: insert byte at its big-endian slot.
	always_ff @(posedge clk) begin
		if (put) begin
			if (pos_q[1:0] == 2'd0)
				block_q[pos_q[5:2]] <= {put_byte, 24'h0};
			else
				block_q[pos_q[5:2]][8*(3-pos_q[1:0]) +: 8] <= put_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			pad_len_q <= '0;
			pos_q <= '0;
			closing_q <= 1'b0;
			pad_mark_q <= 1'b0;
			out_idx_q <= '0;
		end else begin
			if (put) pos_q <= pos_q + 6'd1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser[1]) begin
							closing_q <= 1'b1;
							pad_mark_q <= 1'b1;
							pad_len_q <= len_q + (s_axis_tuser[0] ? 64'd8 : 64'd0);
						end
						if (s_axis_tuser[0]) len_q <= len_q + 64'd8;
						if (s_axis_tuser[0] && pos_q == 6'd63) state_q <= ST_COMP;
						else if (s_axis_tuser[1]) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					pad_mark_q <= 1'b0;
					if (pos_q == 6'd63) state_q <= ST_COMP;
				end
				ST_COMP: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (ctl.done) begin
						if (!closing_q) state_q <= ST_IDLE;
						else state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q <= ST_IDLE;
							closing_q <= 1'b0;
							len_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// After a padding block that reached the length, go out instead.
			if (state_q == ST_WAIT && ctl.done && closing_q && !pad_mark_q && done_len_q)
				state_q <= ST_OUT;
		end
	end

	// 0x80 landed in the length slots: zero-fill this block, length goes in the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tail_q <= 1'b0;
		else if (state_q == ST_PAD && pad_mark_q && pos_q >= sha_pkg::LengthSlot) tail_q <= 1'b1;
		else if (state_q == ST_COMP) tail_q <= 1'b0;
	end

	// Marks that the block in flight carries the length field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_len_q <= 1'b0;
		else if (state_q == ST_PAD && pos_q == 6'd63 && !pad_mark_q && !tail_q)
			done_len_q <= 1'b1;
		else if (state_q == ST_PAD && pos_q == 6'd63) done_len_q <= 1'b0;
		else if (state_q == ST_OUT) done_len_q <= 1'b0;
	end

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .block(block_q),
		.init_chain(init_chain), .chain(chain), .ctl(ctl)
	);

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {4'h0, out_idx_q == 3'd7, out_idx_q, chain[out_idx_q]};
endmodule

// ----- test/tb_sha256_message_hasher.sv -----
// Self-checking testbench for sha256_message_hasher: drives message bytes and
// compares each digest word with a SHA-256 predictor held in a scoreboard class.
// Depends on the RTL top level only.
`timescale 1ns / 100ps

module tb_sha256_message_hasher;
	localparam bit [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam bit [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		bit [31:0] digest;
		bit [2:0] index;
		bit last;
	} digest_word_t;

	class digest_scoreboard;
		bit [31:0] chain [8];
		bit [31:0] blk [16];
		bit [63:0] msg_bits;
		bit [5:0] pos;
		digest_word_t pending_words[$];
		int mismatches;

		function new();
			chain = START_HASH;
			msg_bits = 0;
			pos = 0;
			mismatches = 0;
		endfunction

		function bit [31:0] ror(bit [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] t1, t2;
			for (int t = 0; t < 16; t++)
				w[t] = blk[t];
			for (int t = 16; t < 64; t++)
				w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
					+ (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
			v = chain;
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] += v[i];
		endfunction

		function void absorb(bit [7:0] b);
			bit [31:0] sh;
			sh = b << ((3 - pos[1:0]) * 8);
			if (pos[1:0] == 0)
				blk[pos[5:2]] = sh;
			else
				blk[pos[5:2]] |= sh;
			if (pos == 63)
				compress();
			pos++;
		endfunction

		function void note_input(bit [7:0] b, bit has, bit eom);
			bit [63:0] n;
			if (has) begin
				absorb(b);
				msg_bits += 8;
			end
			if (!eom)
				return;
			n = msg_bits;
			absorb(8'h80);
			while (pos != 56)
				absorb(8'h00);
			for (int i = 7; i >= 0; i--)
				absorb(n[8*i +: 8]);
			for (int i = 0; i < 8; i++)
				pending_words.push_back('{chain[i], 3'(i), i == 7});
			chain = START_HASH;
			msg_bits = 0;
			pos = 0;
		endfunction

		function void fail(string what, bit [39:0] got, digest_word_t exp);
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch (%s): got digest %h index %0d last %b, expected %h %0d %b",
					$time, what, got[31:0], got[34:32], got[35], exp.digest, exp.index, exp.last);
		endfunction

		function void check_result(bit [39:0] got);
			digest_word_t exp;
			if (pending_words.size() == 0) begin
				fail("unexpected word", got, '{0, 0, 0});
				return;
			end
			exp = pending_words.pop_front();
			if (got[31:0] != exp.digest || got[34:32] != exp.index || got[35] != exp.last)
				fail("field", got, exp);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 0;
	logic [1:0] s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [39:0] m_axis_tdata;

	digest_scoreboard sb = new();
	bit quiet = 0;
	int stall_left = 0;
	int items_sent = 0;

	sha256_message_hasher i_dut (.*);

	always #5 clk = ~clk;

	function int draw_wait();
		return quiet ? 0 : $urandom_range(0, 12);
	endfunction

	// Receiver: take a word, then stall a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			int w;
			w = draw_wait();
			sb.check_result(m_axis_tdata);
			stall_left <= w;
			m_axis_tready <= (w == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_word(bit [7:0] b, bit has, bit eom);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= b;
		s_axis_tuser <= {eom, has};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(b, has, eom);
		items_sent++;
	endtask

	// Random message; a few idle words mixed in, last byte may carry the end flag.
	task automatic send_message(int len);
		bit joint;
		joint = (len > 0) && $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(8'($urandom), 0, 0);
			send_word(8'($urandom), 1, joint && i == len - 1);
		end
		if (!joint)
			send_word(8'($urandom), 0, 1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty message, idle word, extremes, "abc" closed with its last byte
		send_word(8'h00, 0, 1);
		send_word(8'hff, 0, 0);
		send_word(8'h00, 1, 0);
		send_word(8'hff, 1, 0);
		send_word(8'h00, 0, 1);
		send_word("a", 1, 0);
		send_word("b", 1, 0);
		send_word("c", 1, 1);
		send_word(8'hff, 1, 1);
		// padding boundaries: marker in the length slots, exact block fill
		send_message(56);
		send_message(64);
		while (items_sent < 150) begin
			quiet = ($urandom_range(0, 4) == 0);
			send_message($urandom_range(0, 20));
		end
		s_axis_tvalid <= 0;
		wait (sb.pending_words.size() == 0);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
